// ===== hw/rtl/gbh_pkg.sv =====
// Shared constants and types for the graph search block.
// No dependencies; used by gbh_adj_mem and graph_bfs_hop_distance.
package gbh_pkg;

    localparam int NODE_W        = 6;
    localparam int COUNT_W       = 7;
    localparam int MODE_W        = 2;
    localparam int DEF_MAX_NODES = 64;
    localparam int NODE_LIMIT    = 64;
    localparam int COUNT_RESET   = 64;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic REG_NODE_COUNT = 1'b0;

    // Control word from the sequencer to the adjacency store.
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic [NODE_W-1:0] wr_addr;
        logic [NODE_W-1:0] rd_addr;
    } t_adj_cmd;

endpackage

// ===== hw/rtl/gbh_adj_mem.sv =====
// Adjacency bit matrix: one row per node, one read and one write port.
// Depends on gbh_pkg for the command struct.
module gbh_adj_mem #(
    parameter int ROWS = gbh_pkg::DEF_MAX_NODES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbh_pkg::t_adj_cmd i_cmd,
    input  logic [ROWS-1:0]   i_wr_row,
    output logic [ROWS-1:0]   o_rd_row
);

    localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROWS-1:0] mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    logic [ROWS-1:0] r_rd_data;
    logic            r_rd_vld;

    // Row valid bits let a whole-graph clear empty every row at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.clr) begin
            r_row_vld <= '0;
        end else if (i_cmd.wr) begin
            r_row_vld[i_cmd.wr_addr[IW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_cmd.wr_addr[IW-1:0]] <= i_wr_row;
        end
        r_rd_data <= mem[i_cmd.rd_addr[IW-1:0]];
        r_rd_vld  <= r_row_vld[i_cmd.rd_addr[IW-1:0]];
    end

    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hw/rtl/graph_bfs_hop_distance.sv =====
// Breadth-first search over an undirected graph held as an adjacency bit matrix.
// Add edge: row read-modify-write of both endpoints. Clear: all rows at once.
// Search: a setup step, then per dequeued node a pop, row read, neighbor fetch
// and one lowest-set-bit scan step per newly found neighbor, a pop that finds the
// queue empty, then per result word an order, load and wait state plus any output
// stall. One word at a time. Reset empties the graph and sets node_count to 64.
module graph_bfs_hop_distance #(
    parameter int MAX_NODES = gbh_pkg::DEF_MAX_NODES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [gbh_pkg::MODE_W-1:0]    i_mode,
    input  logic [gbh_pkg::NODE_W-1:0]    i_first_node,
    input  logic [gbh_pkg::NODE_W-1:0]    i_second_node,
    input  logic [gbh_pkg::NODE_W-1:0]    i_start_node,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gbh_pkg::NODE_W-1:0]    o_node,
    output logic                          o_reached,
    output logic [gbh_pkg::NODE_W-1:0]    o_distance,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbh_pkg::APB_AW-1:0]    paddr,
    input  logic [gbh_pkg::APB_DW-1:0]    pwdata,
    output logic [gbh_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int NW  = gbh_pkg::NODE_W;
    localparam int CTW = gbh_pkg::COUNT_W;
    localparam int CAP = (MAX_NODES < gbh_pkg::NODE_LIMIT) ? MAX_NODES : gbh_pkg::NODE_LIMIT;
    localparam int IW  = $clog2(CAP);
    localparam int QW  = IW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD_WA = 4'd1;
    localparam logic [3:0] S_ADD_WB = 4'd2;
    localparam logic [3:0] S_POP    = 4'd3;
    localparam logic [3:0] S_ROW    = 4'd4;
    localparam logic [3:0] S_NB     = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_ORD    = 4'd7;
    localparam logic [3:0] S_LD     = 4'd8;
    localparam logic [3:0] S_WAIT   = 4'd9;

    logic [3:0]      r_state, n_state;
    logic [CTW-1:0]  r_node_count;
    logic [CTW-1:0]  w_count;
    logic [CAP-1:0]  w_live;
    logic            w_accept;
    logic            w_edge_ok;
    logic            w_start_ok;

    logic [IW-1:0]   r_a, r_b;
    logic [QW-1:0]   r_head, r_tail;
    logic [CAP-1:0]  r_visited;
    logic [CAP-1:0]  r_fresh;
    logic [NW-1:0]   r_dist;
    logic [IW-1:0]   r_idx;
    logic [CAP-1:0]  w_low;
    logic [IW-1:0]   w_low_idx;

    logic [NW-1:0]   hop_mem [CAP];
    logic [NW-1:0]   queue_mem [CAP];
    logic [NW-1:0]   r_hop_rd;
    logic [NW-1:0]   r_q_rd;
    logic [IW-1:0]   w_hop_rd_addr;
    logic            w_hop_wr;
    logic [IW-1:0]   w_hop_wr_addr;
    logic [NW-1:0]   w_hop_wr_data;
    logic            w_q_wr;
    logic [IW-1:0]   w_q_wr_addr;
    logic [NW-1:0]   w_q_wr_data;

    gbh_pkg::t_adj_cmd w_adj_cmd;
    logic [CAP-1:0]  w_adj_wr_row;
    logic [CAP-1:0]  w_adj_rd_row;

    logic            r_o_valid;
    logic [NW-1:0]   r_o_node;
    logic            r_o_reached;
    logic [NW-1:0]   r_o_distance;
    logic            r_o_last;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gbh_pkg::REG_NODE_COUNT)
                  ? gbh_pkg::APB_DW'(r_node_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CTW'(gbh_pkg::COUNT_RESET);
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == gbh_pkg::REG_NODE_COUNT) begin
            r_node_count <= pwdata[CTW-1:0];
        end
    end

    assign w_count = (r_node_count > CTW'(CAP)) ? CTW'(CAP) : r_node_count;

    always_comb begin
        for (int j = 0; j < CAP; j++) begin
            w_live[j] = (CTW'(j) < w_count);
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_edge_ok  = (CTW'(i_first_node) < w_count) && (CTW'(i_second_node) < w_count);
    assign w_start_ok = (CTW'(i_start_node) < w_count);

    // Lowest pending neighbor: isolate the bit, then encode its position.
    assign w_low = r_fresh & (~r_fresh + CAP'(1));
    always_comb begin
        w_low_idx = '0;
        for (int j = 0; j < CAP; j++) begin
            if (w_low[j]) begin
                w_low_idx = w_low_idx | IW'(j);
            end
        end
    end

    // Adjacency store control.
    always_comb begin
        w_adj_cmd      = '0;
        w_adj_wr_row   = '0;
        case (r_state)
            S_IDLE: begin
                w_adj_cmd.rd_addr = i_first_node;
                w_adj_cmd.clr     = w_accept && (i_mode == gbh_pkg::MODE_CLEAR);
            end
            S_ADD_WA: begin
                w_adj_cmd.wr      = 1'b1;
                w_adj_cmd.wr_addr = NW'(r_a);
                w_adj_cmd.rd_addr = NW'(r_b);
                w_adj_wr_row      = w_adj_rd_row | (CAP'(1) << r_b);
            end
            S_ADD_WB: begin
                w_adj_cmd.wr      = 1'b1;
                w_adj_cmd.wr_addr = NW'(r_b);
                w_adj_wr_row      = w_adj_rd_row | (CAP'(1) << r_a);
            end
            S_ROW: begin
                w_adj_cmd.rd_addr = r_q_rd;
            end
            default: begin
                w_adj_cmd.rd_addr = '0;
            end
        endcase
    end

    gbh_adj_mem #(
        .ROWS (CAP)
    ) u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_adj_cmd),
        .i_wr_row (w_adj_wr_row),
        .o_rd_row (w_adj_rd_row)
    );

    // Hop count and pending queue stores.
    assign w_hop_rd_addr = (r_state == S_ROW) ? r_q_rd[IW-1:0] : r_idx;

    always_comb begin
        w_hop_wr      = 1'b0;
        w_hop_wr_addr = i_start_node[IW-1:0];
        w_hop_wr_data = '0;
        w_q_wr        = 1'b0;
        w_q_wr_addr   = '0;
        w_q_wr_data   = i_start_node;
        if (r_state == S_IDLE) begin
            w_hop_wr = w_accept && (i_mode == gbh_pkg::MODE_SEARCH) && w_start_ok;
            w_q_wr   = w_hop_wr;
        end else if (r_state == S_SCAN && r_fresh != '0) begin
            w_hop_wr      = 1'b1;
            w_hop_wr_addr = w_low_idx;
            w_hop_wr_data = r_dist;
            w_q_wr        = (r_tail < QW'(CAP));
            w_q_wr_addr   = r_tail[IW-1:0];
            w_q_wr_data   = NW'(w_low_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hop_wr) begin
            hop_mem[w_hop_wr_addr] <= w_hop_wr_data;
        end
        if (w_q_wr) begin
            queue_mem[w_q_wr_addr] <= w_q_wr_data;
        end
        r_hop_rd <= hop_mem[w_hop_rd_addr];
        r_q_rd   <= queue_mem[r_head[IW-1:0]];
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == gbh_pkg::MODE_ADD && w_edge_ok) begin
                        n_state = S_ADD_WA;
                    end else if (i_mode == gbh_pkg::MODE_SEARCH && w_count != '0) begin
                        n_state = S_POP;
                    end
                end
            end
            S_ADD_WA: n_state = S_ADD_WB;
            S_ADD_WB: n_state = S_IDLE;
            S_POP:    n_state = (r_head < r_tail) ? S_ROW : S_ORD;
            S_ROW:    n_state = S_NB;
            S_NB:     n_state = S_SCAN;
            S_SCAN:   n_state = (r_fresh == '0) ? S_POP : S_SCAN;
            S_ORD:    n_state = S_LD;
            S_LD:     n_state = S_WAIT;
            S_WAIT: begin
                if (!i_stall) begin
                    n_state = r_o_last ? S_IDLE : S_ORD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LD) begin
                r_o_valid <= 1'b1;
            end else if (r_state == S_WAIT && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a    <= i_first_node[IW-1:0];
                r_b    <= i_second_node[IW-1:0];
                r_head <= '0;
                r_idx  <= '0;
                if (w_accept && i_mode == gbh_pkg::MODE_SEARCH) begin
                    if (w_start_ok) begin
                        r_visited <= CAP'(1) << i_start_node[IW-1:0];
                        r_tail    <= QW'(1);
                    end else begin
                        r_visited <= '0;
                        r_tail    <= '0;
                    end
                end
            end
            S_POP: begin
                if (r_head < r_tail) begin
                    r_head <= r_head + QW'(1);
                end
            end
            S_NB: begin
                r_fresh <= w_adj_rd_row & w_live & ~r_visited;
                r_dist  <= r_hop_rd + NW'(1);
            end
            S_SCAN: begin
                if (r_fresh != '0) begin
                    r_visited <= r_visited | w_low;
                    r_fresh   <= r_fresh & ~w_low;
                    if (r_tail < QW'(CAP)) begin
                        r_tail <= r_tail + QW'(1);
                    end
                end
            end
            S_LD: begin
                r_o_node     <= NW'(r_idx);
                r_o_reached  <= r_visited[r_idx];
                r_o_distance <= r_visited[r_idx] ? r_hop_rd : '0;
                r_o_last     <= (CTW'(r_idx) + CTW'(1)) == w_count;
            end
            S_WAIT: begin
                if (!i_stall && !r_o_last) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_valid    = r_o_valid;
    assign o_node     = r_o_node;
    assign o_reached  = r_o_reached;
    assign o_distance = r_o_distance;
    assign o_last     = r_o_last;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for graph_bfs_hop_distance: edge loads, graph clears and
// hop-distance searches, checked word by word against a breadth-first predictor.
// Depends on gbh_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int NODE_W     = gbh_pkg::NODE_W;
    localparam int MODE_W     = gbh_pkg::MODE_W;
    localparam int COUNT_W    = gbh_pkg::COUNT_W;
    localparam int NODE_LIMIT = gbh_pkg::NODE_LIMIT;
    localparam int APB_AW     = gbh_pkg::APB_AW;
    localparam int APB_DW     = gbh_pkg::APB_DW;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] NODE_COUNT_ADDR =
        APB_AW'(4 * int'(gbh_pkg::REG_NODE_COUNT));
    localparam int SETTLE_CYCLES = 700;
    localparam int LONG_HOLD     = 900;
    localparam int CYCLE_LIMIT   = 4000000;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              reached;
        logic [NODE_W-1:0] distance;
        logic              last;
    } t_hop_report;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic [MODE_W-1:0]   i_mode        = gbh_pkg::MODE_ADD;
    logic [NODE_W-1:0]   i_first_node  = '0;
    logic [NODE_W-1:0]   i_second_node = '0;
    logic [NODE_W-1:0]   i_start_node  = '0;
    logic                i_stall       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [APB_AW-1:0]   paddr         = '0;
    logic [APB_DW-1:0]   pwdata        = '0;
    logic                o_stall;
    logic                o_valid;
    logic [NODE_W-1:0]   o_node;
    logic                o_reached;
    logic [NODE_W-1:0]   o_distance;
    logic                o_last;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Predictor state: adjacency matrix and node_count as the block should hold them.
    logic [NODE_LIMIT-1:0] adj_model [NODE_LIMIT];
    logic [COUNT_W-1:0]    node_count_shadow;
    t_hop_report           expected_hops [$];

    int          mismatch_count = 0;
    bit          quiet          = 1'b0;
    int          hold_requests  = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;
    int          stall_left     = 0;
    int          calm_left      = 0;
    int unsigned cycle_count    = 0;

    graph_bfs_hop_distance uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_first_node  (i_first_node),
        .i_second_node (i_second_node),
        .i_start_node  (i_start_node),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_node        (o_node),
        .o_reached     (o_reached),
        .o_distance    (o_distance),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_nodes();
        return (int'(node_count_shadow) > NODE_LIMIT) ? NODE_LIMIT : int'(node_count_shadow);
    endfunction

    // Updates the graph model for one accepted word and queues the words a search yields.
    function automatic void apply_graph_request(input logic [MODE_W-1:0] mode,
                                                input logic [NODE_W-1:0] a,
                                                input logic [NODE_W-1:0] b,
                                                input logic [NODE_W-1:0] s);
        int                    eff;
        int                    head;
        int                    tail;
        int                    parent;
        logic [NODE_LIMIT-1:0] live;
        logic [NODE_LIMIT-1:0] seen;
        logic [NODE_LIMIT-1:0] fresh;
        logic [NODE_W-1:0]     depth [NODE_LIMIT];
        logic [NODE_W-1:0]     order [NODE_LIMIT];
        t_hop_report           r;
        eff = active_nodes();
        case (mode)
            gbh_pkg::MODE_ADD: begin
                if (int'(a) < eff && int'(b) < eff) begin
                    adj_model[a][b] = 1'b1;
                    adj_model[b][a] = 1'b1;
                end
            end
            gbh_pkg::MODE_CLEAR: begin
                for (int i = 0; i < NODE_LIMIT; i++) adj_model[i] = '0;
            end
            gbh_pkg::MODE_SEARCH: begin
                live = (eff >= NODE_LIMIT) ? '1 : ((NODE_LIMIT'(1) << eff) - 1'b1);
                seen = '0;
                if (int'(s) < eff) begin
                    seen[s]  = 1'b1;
                    depth[s] = '0;
                    order[0] = s;
                    head     = 0;
                    tail     = 1;
                    while (head < tail) begin
                        parent = int'(order[head]);
                        head++;
                        fresh = adj_model[parent] & live & ~seen;
                        for (int k = 0; k < NODE_LIMIT; k++) begin
                            if (fresh[k]) begin
                                seen[k]     = 1'b1;
                                depth[k]    = depth[parent] + 1'b1;
                                order[tail] = NODE_W'(k);
                                tail++;
                            end
                        end
                    end
                end
                for (int i = 0; i < eff; i++) begin
                    r.node     = NODE_W'(i);
                    r.reached  = seen[i];
                    r.distance = seen[i] ? depth[i] : '0;
                    r.last     = (i == eff - 1);
                    expected_hops = {expected_hops, r};
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Offers one word, with an occasional gap first, and returns once it is taken.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b, input logic [NODE_W-1:0] s);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_first_node  <= a;
        i_second_node <= b;
        i_start_node  <= s;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        apply_graph_request(mode, a, b, s);
    endtask

    task automatic add_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
        send_request(gbh_pkg::MODE_ADD, a, b, NODE_W'($urandom));
    endtask

    task automatic search_from(input logic [NODE_W-1:0] s);
        send_request(gbh_pkg::MODE_SEARCH, NODE_W'($urandom), NODE_W'($urandom), s);
    endtask

    // Drops valid, waits for every expected word, then lets a trailing edge load finish.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_hops.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_node_count();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= NODE_COUNT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata[COUNT_W-1:0] !== node_count_shadow) begin
            mismatch_count++;
            $display("%0t: node_count read expected %0d, got %0d",
                     $time, node_count_shadow, prdata[COUNT_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_node_count(input logic [APB_DW-1:0] value);
        settle_block();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        node_count_shadow = value[COUNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        check_node_count();
    endtask

    // Duplicates, a self loop, the widest endpoints and an unknown mode at full count.
    task automatic test_edge_rules();
        add_edge(6'd0, 6'd1);
        add_edge(6'd1, 6'd2);
        add_edge(6'd1, 6'd0);
        add_edge(6'd5, 6'd5);
        add_edge(6'd62, 6'd63);
        add_edge(6'd63, 6'd0);
        send_request(MODE_UNUSED, 6'd63, 6'd63, 6'd63);
        search_from(6'd0);
        search_from(6'd63);
        search_from(6'd5);
        settle_block();
    endtask

    // Node count lowered over stored edges, out-of-range endpoints and starts,
    // saturation above the limit, a count of zero and a count of one, then a clear.
    task automatic test_count_limits();
        set_node_count(32'h0000_000A);
        add_edge(6'd3, 6'd12);
        add_edge(6'd2, 6'd9);
        search_from(6'd9);
        search_from(6'd15);
        set_node_count(32'hFFFF_FFFF);
        search_from(6'd62);
        set_node_count(32'h0000_0000);
        search_from(6'd0);
        add_edge(6'd3, 6'd4);
        set_node_count(32'h0000_0001);
        search_from(6'd0);
        set_node_count(gbh_pkg::COUNT_RESET);
        search_from(6'd3);
        send_request(gbh_pkg::MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                     NODE_W'($urandom));
        search_from(6'd63);
        settle_block();
    endtask

    // The receiver holds off for a long stretch while searches keep arriving,
    // so the block stays busy and stalls its input.
    task automatic test_output_hold_off();
        set_node_count(gbh_pkg::COUNT_RESET);
        send_request(gbh_pkg::MODE_CLEAR, 6'd0, 6'd0, 6'd0);
        for (int i = 0; i < 20; i++) add_edge(NODE_W'(i), NODE_W'(i + 1));
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 4; i++) begin
            search_from(NODE_W'($urandom_range(0, 20)));
            add_edge(NODE_W'($urandom_range(20, 40)), NODE_W'($urandom_range(20, 40)));
        end
        settle_block();
    endtask

    task automatic test_random_traffic();
        int phase_counts [8];
        int eff;
        int sent;
        int pick;
        int a;
        int b;
        phase_counts = '{64, 5, 33, 100, 2, 17, 48, 64};
        for (int p = 0; p < 8; p++) begin
            set_node_count(APB_DW'(phase_counts[p]));
            // No idling on either side in the last phase.
            if (p == 7) quiet <= 1'b1;
            eff  = active_nodes();
            sent = 0;
            while (sent < 42) begin
                pick = $urandom_range(0, 99);
                a    = $urandom_range(0, eff - 1);
                // Half the in-range edges extend a chain so searches run deep.
                b    = ($urandom_range(0, 1) == 0) ? ((a + 1 < eff) ? a + 1 : 0)
                                                   : $urandom_range(0, eff - 1);
                if (pick < 45) begin
                    add_edge(NODE_W'(a), NODE_W'(b));
                end else if (pick < 55) begin
                    add_edge(NODE_W'($urandom), NODE_W'($urandom));
                end else if (pick < 85) begin
                    search_from(NODE_W'($urandom_range(0, eff - 1)));
                end else if (pick < 90) begin
                    search_from(NODE_W'($urandom));
                end else if (pick < 94) begin
                    send_request(gbh_pkg::MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                                 NODE_W'($urandom));
                end else begin
                    send_request(MODE_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                                 NODE_W'($urandom));
                    sent--;
                end
                sent++;
            end
        end
    endtask

    // Receiver: random stall bursts and calm runs, or one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            i_stall <= 1'b1;
        end else begin
            calm_left = $urandom_range(1, 24) - 1;
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_hop_report want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_hops.size() == 0) begin
                mismatch_count++;
                $display({"%0t: unexpected word, expected none, got node %0d reached %0b ",
                          "distance %0d last %0b"},
                         $time, o_node, o_reached, o_distance, o_last);
            end else begin
                want = expected_hops.pop_front();
                if (o_node !== want.node || o_reached !== want.reached ||
                    o_distance !== want.distance || o_last !== want.last) begin
                    mismatch_count++;
                    $display({"%0t: word mismatch, expected/actual: node %0d/%0d ",
                              "reached %0b/%0b distance %0d/%0d last %0b/%0b"},
                             $time, want.node, o_node, want.reached, o_reached,
                             want.distance, o_distance, want.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NODE_LIMIT; i++) adj_model[i] = '0;
        node_count_shadow = COUNT_W'(gbh_pkg::COUNT_RESET);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_node_count();
        test_edge_rules();
        test_count_limits();
        test_output_hold_off();
        test_random_traffic();
        settle_block();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
